// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the core RTL.
// Both macros assume the enclosing module has clk_i; LCT_ASSERT also needs rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define LCT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define LCT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/lct_pkg.sv =====
package lct_pkg;

  // Value returned by a get that finds no entry.
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  // Request kinds carried in the request tuser bit.
  localparam logic ReqGet = 1'b0;
  localparam logic ReqPut = 1'b1;

  // Fixed-width part of one stored entry; the use count travels beside it.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] touch;
  } entry_t;

  // Status of one finished scan.
  typedef struct packed {
    logic found;
    logic free_vld;
    logic victim_vld;
  } scan_flags_t;

endpackage

// ===== rtl/core/lct_entry_mem.sv =====
module lct_entry_mem #(
  parameter int unsigned Depth  = 16,
  parameter int unsigned CountW = 16,
  parameter int unsigned IdxW   = 4
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  lct_pkg::entry_t       wr_ent_i,
  input  logic [CountW-1:0]     wr_count_i,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  output lct_pkg::entry_t       rd_ent_o,
  output logic [CountW-1:0]     rd_count_o
);
  import lct_pkg::*;

  entry_t            ent_mem   [Depth];
  logic [CountW-1:0] count_mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ent_mem[wr_addr_i]   <= wr_ent_i;
      count_mem[wr_addr_i] <= wr_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_ent_o   <= ent_mem[rd_addr_i];
      rd_count_o <= count_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/lct_scan_unit.sv =====
module lct_scan_unit #(
  parameter int unsigned CountW = 16,
  parameter int unsigned IdxW   = 4,
  parameter int unsigned HeldW  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  ent_vld_i,
  input  logic [IdxW-1:0]       ent_idx_i,
  input  lct_pkg::entry_t       ent_i,
  input  logic [CountW-1:0]     ent_count_i,
  input  logic [31:0]           key_i,
  input  logic [31:0]           now_i,
  output lct_pkg::scan_flags_t  flags_o,
  output logic [IdxW-1:0]       found_idx_o,
  output logic [31:0]           found_value_o,
  output logic [CountW-1:0]     found_count_o,
  output logic [IdxW-1:0]       free_idx_o,
  output logic [IdxW-1:0]       victim_idx_o,
  output logic [HeldW-1:0]      held_o
);
  import lct_pkg::*;

  scan_flags_t       flags_q, flags_d;
  logic [IdxW-1:0]   found_idx_q, found_idx_d;
  logic [31:0]       found_value_q, found_value_d;
  logic [CountW-1:0] found_count_q, found_count_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic [IdxW-1:0]   victim_idx_q, victim_idx_d;
  logic [CountW-1:0] victim_count_q, victim_count_d;
  logic [31:0]       victim_age_q, victim_age_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [31:0]       age;
  logic              better;

  // Age of the entry under the read port, modulo 2^32.
  assign age = now_i - ent_i.touch;

  // Lower count wins; on equal count the older entry wins, the earlier index on a full tie.
  assign better = !flags_q.victim_vld || (ent_count_i < victim_count_q) ||
                  ((ent_count_i == victim_count_q) && (age > victim_age_q));

  // One entry per cycle, while ent_vld_i is high, is folded into the running match, free slot, victim and held count.
  always_comb begin
    flags_d        = flags_q;
    found_idx_d    = found_idx_q;
    found_value_d  = found_value_q;
    found_count_d  = found_count_q;
    free_idx_d     = free_idx_q;
    victim_idx_d   = victim_idx_q;
    victim_count_d = victim_count_q;
    victim_age_d   = victim_age_q;
    held_d         = held_q;
    if (start_i) begin
      flags_d = '0;
      held_d  = '0;
    end else if (ent_vld_i) begin
      if (!ent_i.valid) begin
        if (!flags_q.free_vld) begin
          flags_d.free_vld = 1'b1;
          free_idx_d       = ent_idx_i;
        end
      end else begin
        held_d = held_q + HeldW'(1);
        if (!flags_q.found && (ent_i.key == key_i)) begin
          flags_d.found = 1'b1;
          found_idx_d   = ent_idx_i;
          found_value_d = ent_i.value;
          found_count_d = ent_count_i;
        end
        if (better) begin
          flags_d.victim_vld = 1'b1;
          victim_idx_d       = ent_idx_i;
          victim_count_d     = ent_count_i;
          victim_age_d       = age;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      held_q  <= '0;
    end else begin
      flags_q <= flags_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q    <= found_idx_d;
    found_value_q  <= found_value_d;
    found_count_q  <= found_count_d;
    free_idx_q     <= free_idx_d;
    victim_idx_q   <= victim_idx_d;
    victim_count_q <= victim_count_d;
    victim_age_q   <= victim_age_d;
  end

  assign flags_o       = flags_q;
  assign found_idx_o   = found_idx_q;
  assign found_value_o = found_value_q;
  assign found_count_o = found_count_q;
  assign free_idx_o    = free_idx_q;
  assign victim_idx_o  = victim_idx_q;
  assign held_o        = held_q;

endmodule

// ===== rtl/core/lfu_cache_table.sv =====
// Channel   Dir  Payload (low bit up)                        Handshake
// s_axis    in   tuser: req_type; tdata: req_key, req_value   tvalid/tready
// m_axis    out  tuser: hit; tdata: read_value                tvalid/tready
// cfg       in   cfg_data_i: capacity_in_use                  cfg_valid_i/cfg_ready_o
//
// A request passes through accept, a read of every entry through the single
// entry memory read port, a drain state and a write-back state.
// After reset a clearing pass marks every entry empty; no request is taken
// meanwhile, configuration writes are.
// The write-back waits while the output register holds an unaccepted result.
module lfu_cache_table #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // req_key [31:0], req_value [63:32]
  input  logic [0:0]  s_axis_tuser,   // req_type [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_value [31:0]
  output logic [0:0]  m_axis_tuser,   // hit [0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i      // capacity_in_use
);
  import lct_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned HeldW   = (CntW > 5) ? CntW : 5;

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StScan  = 5'b00100,
    StDrain = 5'b01000,
    StWrite = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              dv_q;
  logic [IdxW-1:0]   didx_q;
  logic [4:0]        cap_q;
  logic [31:0]       touch_q;
  logic              req_put_q;
  logic [31:0]       req_key_q;
  logic [31:0]       req_value_q;
  logic              m_valid_q;
  logic              m_hit_q;
  logic [31:0]       m_data_q;

  logic              accept;
  logic              last_idx;
  logic              out_free;
  logic              wr_fire;

  logic              mem_wr_en;
  logic [IdxW-1:0]   mem_wr_addr;
  entry_t            mem_wr_ent;
  logic [COUNT_BITS-1:0] mem_wr_count;
  logic              mem_rd_en;
  entry_t            mem_rd_ent;
  logic [COUNT_BITS-1:0] mem_rd_count;

  scan_flags_t       flags;
  logic [IdxW-1:0]   found_idx;
  logic [31:0]       found_value;
  logic [COUNT_BITS-1:0] found_count;
  logic [IdxW-1:0]   free_idx;
  logic [IdxW-1:0]   victim_idx;
  logic [CntW-1:0]   held;

  logic [HeldW-1:0]  cap_ext;
  logic [HeldW-1:0]  cap_eff;
  logic              cap_zero;
  logic              use_victim;
  logic              upd_en;
  logic [IdxW-1:0]   upd_addr;
  entry_t            upd_ent;
  logic [COUNT_BITS-1:0] upd_count;
  logic              res_hit;
  logic [31:0]       res_data;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign last_idx = (idx_q == CntW'(CAPACITY - 1));
  assign out_free = !m_valid_q || m_axis_tready;
  assign wr_fire  = (state_q == StWrite) && out_free;

  // Effective capacity is the register clipped to the table depth.
  assign cap_ext  = HeldW'(cap_q);
  assign cap_eff  = (cap_ext > HeldW'(CAPACITY)) ? HeldW'(CAPACITY) : cap_ext;
  assign cap_zero = (cap_q == 5'd0);

  // Decide the write-back and the result from the finished scan.
  always_comb begin
    upd_en          = 1'b0;
    upd_addr        = found_idx;
    upd_ent.valid   = 1'b1;
    upd_ent.key     = req_key_q;
    upd_ent.value   = req_value_q;
    upd_ent.touch   = touch_q;
    upd_count       = '0;
    use_victim      = 1'b0;
    res_hit         = 1'b0;
    res_data        = '0;
    if (flags.found) begin
      res_hit = 1'b1;
      if (!req_put_q) begin
        res_data      = found_value;
        upd_ent.value = found_value;
      end
      upd_en    = !req_put_q || !cap_zero;
      upd_count = (found_count == '1) ? found_count : found_count + COUNT_BITS'(1);
    end else if (!req_put_q) begin
      res_data = MissValue;
    end else if (!cap_zero) begin
      use_victim = ((HeldW'(held) >= cap_eff) || !flags.free_vld) && flags.victim_vld;
      upd_en     = use_victim || flags.free_vld;
      upd_addr   = use_victim ? victim_idx : free_idx;
    end
  end

  // Sequencer: clearing pass, then one request at a time.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      StClear: begin
        idx_d = last_idx ? '0 : idx_q + CntW'(1);
        if (last_idx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StScan;
          idx_d   = '0;
        end
      end
      StScan: begin
        idx_d = last_idx ? '0 : idx_q + CntW'(1);
        if (last_idx) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StWrite;
      end
      StWrite: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StClear;
        idx_d   = '0;
      end
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      idx_q     <= '0;
      dv_q      <= 1'b0;
      cap_q     <= 5'd16;
      touch_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dv_q    <= (state_q == StScan);
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (wr_fire) begin
        touch_q   <= touch_q + 32'd1;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    didx_q <= idx_q[IdxW-1:0];
    if (accept) begin
      req_put_q   <= s_axis_tuser[0];
      req_key_q   <= s_axis_tdata[31:0];
      req_value_q <= s_axis_tdata[63:32];
    end
    if (wr_fire) begin
      m_hit_q  <= res_hit;
      m_data_q <= res_data;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tuser[0] = m_hit_q;
  assign m_axis_tdata    = m_data_q;

  // Memory port selection: clearing pass or write-back.
  always_comb begin
    if (state_q == StClear) begin
      mem_wr_en        = 1'b1;
      mem_wr_addr      = idx_q[IdxW-1:0];
      mem_wr_ent       = upd_ent;
      mem_wr_ent.valid = 1'b0;
      mem_wr_count     = '0;
    end else begin
      mem_wr_en    = wr_fire && upd_en;
      mem_wr_addr  = upd_addr;
      mem_wr_ent   = upd_ent;
      mem_wr_count = upd_count;
    end
  end

  assign mem_rd_en = (state_q == StScan);

  lct_entry_mem #(
    .Depth  (CAPACITY),
    .CountW (COUNT_BITS),
    .IdxW   (IdxW)
  ) u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (mem_wr_addr),
    .wr_ent_i   (mem_wr_ent),
    .wr_count_i (mem_wr_count),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (idx_q[IdxW-1:0]),
    .rd_ent_o   (mem_rd_ent),
    .rd_count_o (mem_rd_count)
  );

  lct_scan_unit #(
    .CountW (COUNT_BITS),
    .IdxW   (IdxW),
    .HeldW  (CntW)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .ent_vld_i     (dv_q),
    .ent_idx_i     (didx_q),
    .ent_i         (mem_rd_ent),
    .ent_count_i   (mem_rd_count),
    .key_i         (req_key_q),
    .now_i         (touch_q),
    .flags_o       (flags),
    .found_idx_o   (found_idx),
    .found_value_o (found_value),
    .found_count_o (found_count),
    .free_idx_o    (free_idx),
    .victim_idx_o  (victim_idx),
    .held_o        (held)
  );

  `LCT_ASSERT(a_accept_starts_scan, accept |=> (state_q == StScan), "accept did not start a scan")
  `LCT_ASSERT(a_no_write_in_scan, (state_q == StScan) |-> !mem_wr_en, "memory written during scan")
  `LCT_ASSERT(a_found_needs_held, ((state_q == StWrite) && flags.found) |-> (held != '0), "match with no held entry")
  `LCT_ASSERT(a_touch_per_request, wr_fire |=> (touch_q == $past(touch_q) + 32'd1), "touch clock did not advance")

endmodule

// ===== tb/lfu_cache_checker.sv =====
// Watches the request, result and configuration channels of lfu_cache_table,
// predicts every result from its own copy of the store and compares the two.
module lfu_cache_checker #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,   // req_key [31:0], req_value [63:32]
  input  logic [0:0]  s_axis_tuser_i,   // req_type [0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // read_value [31:0]
  input  logic [0:0]  m_axis_tuser_i,   // hit [0]
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  cfg_data_i,       // capacity_in_use
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned hit_total_o
);
  import lct_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } reply_t;

  // Shadow copy of the store.
  logic                  slot_valid [CAPACITY];
  logic [31:0]           slot_key   [CAPACITY];
  logic [31:0]           slot_value [CAPACITY];
  logic [31:0]           slot_touch [CAPACITY];
  logic [COUNT_BITS-1:0] slot_uses  [CAPACITY];
  logic [31:0]           request_clock;
  logic [4:0]            capacity_reg;

  reply_t      expected_replies [$];
  int unsigned mismatches;
  int unsigned hits_seen;

  // Applies one request to the shadow store and returns the result it should give.
  function automatic reply_t serve_request(input logic kind, input logic [31:0] key,
                                           input logic [31:0] data);
    int                    found;
    int                    free_idx;
    int                    victim;
    int                    slot;
    int unsigned           held;
    int unsigned           eff_cap;
    logic [COUNT_BITS-1:0] victim_uses;
    logic [31:0]           victim_age;
    logic [31:0]           age;
    reply_t                reply;
    found       = -1;
    free_idx    = -1;
    victim      = -1;
    held        = 0;
    victim_uses = '0;
    victim_age  = '0;
    reply       = '0;
    eff_cap     = (capacity_reg > CAPACITY) ? CAPACITY : capacity_reg;

    // Scan for the key, the first free slot and the eviction candidate.
    for (int i = 0; i < CAPACITY; i++) begin
      if (!slot_valid[i]) begin
        if (free_idx < 0) free_idx = i;
      end else begin
        held++;
        if (found < 0 && slot_key[i] == key) found = i;
        age = request_clock - slot_touch[i];
        if (victim < 0 || slot_uses[i] < victim_uses ||
            (slot_uses[i] == victim_uses && age > victim_age)) begin
          victim      = i;
          victim_uses = slot_uses[i];
          victim_age  = age;
        end
      end
    end

    if (found >= 0) begin
      reply.hit = 1'b1;
      if (kind == ReqGet) reply.read_value = slot_value[found];
      // A put with zero capacity leaves even a present entry alone.
      if (kind == ReqGet || eff_cap != 0) begin
        if (kind == ReqPut) slot_value[found] = data;
        if (slot_uses[found] != '1) slot_uses[found] = slot_uses[found] + 1'b1;
        slot_touch[found] = request_clock;
      end
    end else if (kind == ReqGet) begin
      reply.read_value = lct_pkg::MissValue;
    end else if (eff_cap != 0) begin
      // A new key: evict one entry when full or over capacity.
      slot = free_idx;
      if ((held >= eff_cap || slot < 0) && victim >= 0) begin
        slot_valid[victim] = 1'b0;
        slot = victim;
      end
      if (slot >= 0) begin
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = data;
        slot_uses[slot]  = '0;
        slot_touch[slot] = request_clock;
      end
    end

    request_clock = request_clock + 1'b1;
    return reply;
  endfunction

  // Track configuration, check results and predict new requests at each edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor_blk
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_valid[i] = 1'b0;
      request_clock = '0;
      capacity_reg  = 5'd16;
      expected_replies.delete();
      mismatches    = 0;
      hits_seen     = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
      hit_total_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity_reg = cfg_data_i;

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.hit        = m_axis_tuser_i[0];
        got.read_value = m_axis_tdata_i;
        if (expected_replies.size() == 0) begin
          $error("result with no request pending: hit %0d, read_value %h",
                 got.hit, got.read_value);
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          if (got.hit != want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            mismatches++;
          end
          if (got.read_value != want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            mismatches++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = serve_request(s_axis_tuser_i[0], s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]);
        if (want.hit) hits_seen++;
        expected_replies = {expected_replies, want};
      end

      fail_count_o  <= mismatches;
      outstanding_o <= expected_replies.size();
      hit_total_o   <= hits_seen;
    end
  end

endmodule

// ===== tb/tb_lfu_cache_table.sv =====
// Drives requests and capacity writes into lfu_cache_table and gives the verdict;
// lfu_cache_checker does the prediction and comparison.
module tb_lfu_cache_table;
  import lct_pkg::*;

  localparam int unsigned Capacity       = 16;
  localparam int unsigned CountBits      = 16;
  localparam int unsigned SettleCycles   = Capacity + 4;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned SegmentItems   = 103;
  localparam int unsigned SegmentCount   = 18;
  localparam int unsigned HotKeyHits     = 20;
  localparam int unsigned PoolSize       = 24;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i    = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned hit_total;
  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 64;
  int unsigned requests_sent = 0;
  int unsigned stall_cycles  = 0;
  logic [31:0] key_pool [PoolSize];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  lfu_cache_table #(
    .CAPACITY  (Capacity),
    .COUNT_BITS(CountBits)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  lfu_cache_checker #(
    .CAPACITY  (Capacity),
    .COUNT_BITS(CountBits)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .hit_total_o    (hit_total)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when no channel has moved anything for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("lfu_cache_table: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one request after a random idle gap and hold it until accepted.
  task automatic send_request(input logic kind, input logic [31:0] key,
                              input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {data, key};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Stop offering requests and wait until every predicted result has arrived.
  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Write the capacity register once the block has gone idle.
  task automatic set_capacity(input logic [4:0] cap);
    drain_requests();
    // The last write-back lands at the same edge that registers its result, before the result leaves.
    repeat (SettleCycles) @(posedge clk_i);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [4:0]  cap_now;
    logic [31:0] key;
    logic        kind;
    int unsigned span;
    logic [31:0] hot_key;

    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme keys and values at the reset capacity.
    send_request(ReqGet, 32'h0000_0000, 32'h1234_5678);
    send_request(ReqPut, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(ReqPut, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(ReqPut, 32'h0000_0000, 32'h0000_0000);
    send_request(ReqPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ReqGet, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(ReqGet, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ReqPut, 32'h0000_0000, 32'h0000_007B);
    send_request(ReqGet, 32'h0000_0000, 32'h0000_0000);

    // Capacity dropped below the entries held: each new key evicts one.
    set_capacity(5'd2);
    send_request(ReqPut, 32'h0000_1001, 32'hA5A5_A5A5);
    send_request(ReqPut, 32'h0000_1002, 32'h5A5A_5A5A);
    send_request(ReqGet, 32'hFFFF_FFFF, 32'h0000_0000);

    // Zero capacity: puts change nothing, gets still see old entries.
    set_capacity(5'd0);
    send_request(ReqPut, 32'h0000_2001, 32'h1111_1111);
    send_request(ReqPut, 32'h0000_1002, 32'h2222_2222);
    send_request(ReqGet, 32'h0000_1002, 32'h0000_0000);
    send_request(ReqGet, 32'h0000_2001, 32'h0000_0000);

    // Equal counts: the entry touched longest ago goes first.
    set_capacity(5'd3);
    send_request(ReqPut, 32'h0000_3001, 32'h0000_0001);
    send_request(ReqPut, 32'h0000_3002, 32'h0000_0002);
    send_request(ReqGet, 32'h0000_3001, 32'h0000_0000);
    send_request(ReqPut, 32'h0000_3003, 32'h0000_0003);
    send_request(ReqGet, 32'h0000_3002, 32'h0000_0000);

    // Random segments, each at its own capacity, in three idling phases.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      case (seg % 6)
        0:       cap_now = 5'd1;
        1:       cap_now = 5'd16;
        2:       cap_now = 5'd0;
        3:       cap_now = 5'd31;
        4:       cap_now = 5'd4;
        default: cap_now = 5'($urandom_range(31));
      endcase
      set_capacity(cap_now);
      case (seg / 6)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 4; p < PoolSize; p++) key_pool[p] = $urandom;
      // A pool a little larger than the capacity keeps hits and evictions both common.
      span = ((cap_now > Capacity) ? Capacity : cap_now) + 4;
      for (int n = 0; n < SegmentItems; n++) begin
        if (n == SegmentItems / 2) drain_requests();
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span - 1)];
        else key = $urandom;
        kind = ($urandom_range(1) == 1) ? ReqPut : ReqGet;
        send_request(kind, key, $urandom);
      end
    end

    // Raise one key's use count well above the others, then force evictions.
    set_capacity(5'd2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hot_key = $urandom;
    send_request(ReqPut, hot_key, $urandom);
    repeat (HotKeyHits) send_request(ReqGet, hot_key, $urandom);
    send_request(ReqPut, ~hot_key, $urandom);
    send_request(ReqPut, hot_key ^ 32'h0000_0001, $urandom);
    send_request(ReqGet, hot_key, $urandom);

    drain_requests();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Ran %0d requests (%0d hits) at capacities 0 through 31 under three idling mixes,",
             requests_sent, hit_total);
    $display("including extreme keys, over-capacity eviction and a heavily reused key.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("lfu_cache_table: match");
    end else begin
      $display("lfu_cache_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lct_pkg.sv
rtl/core/lct_entry_mem.sv
rtl/core/lct_scan_unit.sv
rtl/core/lfu_cache_table.sv
tb/lfu_cache_checker.sv
tb/tb_lfu_cache_table.sv
